@@ rtl/core/kvc_pkg.sv @@
// Package for the FIFO-replacement key-value cache.
// Holds sizes, the request code enum, transaction payload structs and internal control structs.
// No dependencies.
package kvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_EXIST  = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] family_id;
    logic [15:0] column_id;
    logic [31:0] row_id;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic        deleted;
    logic [31:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic             tomb;
    logic [VAL_W-1:0] value;
  } match_t;

  typedef struct packed {
    logic             evict;
    logic [IDX_W-1:0] evict_idx;
    logic             wr;
    logic             wr_key;
    logic             mark;
    logic [IDX_W-1:0] wr_idx;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } store_wr_t;

endpackage

@@ rtl/core/kvc_entry_store.sv @@
// Entry storage of the key-value cache: valid, tombstone, key and value per entry.
// Parallel key compare against all valid entries; writes come as a store_wr_t. Uses kvc_pkg.
module kvc_entry_store
  import kvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] lookup_key,
  input  store_wr_t        wr,
  output match_t           match
);

  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] tomb_r;
  logic [KEY_W-1:0]   key_r [ENTRIES];
  logic [VAL_W-1:0]   value_r [ENTRIES];
  logic [ENTRIES-1:0] hit_vec;

  always_comb begin
    match = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == lookup_key);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        match.idx   = match.idx | IDX_W'(i);
        match.tomb  = match.tomb | tomb_r[i];
        match.value = match.value | value_r[i];
      end
    end
    match.hit = |hit_vec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      tomb_r  <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (wr.evict && wr.evict_idx == IDX_W'(i)) begin
          valid_r[i] <= 1'b0;
          tomb_r[i]  <= 1'b0;
        end
        if (wr.wr && wr.wr_idx == IDX_W'(i)) begin
          tomb_r[i] <= 1'b0;
          if (wr.wr_key) begin
            valid_r[i] <= 1'b1;
          end
        end
        if (wr.mark && wr.wr_idx == IDX_W'(i)) begin
          tomb_r[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr.wr && wr.wr_idx == IDX_W'(i)) begin
        value_r[i] <= wr.value;
        if (wr.wr_key) begin
          key_r[i] <= wr.key;
        end
      end
    end
  end

endmodule

@@ rtl/core/kvc_policy.sv @@
// Request decode and FIFO replacement control: capacity register, insert pointer, fill count.
// Produces store writes and the result item from a request and its match. Uses kvc_pkg.
module kvc_policy
  import kvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             fire,
  input  in_item_t         req,
  input  match_t           match,
  output store_wr_t        wr,
  output out_item_t        result
);

  logic [CAP_W-1:0] cap_r;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] ptr_ext;
  logic [CNT_W-1:0] oldest;
  logic             insert;
  logic             evict;

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if ({1'b0, cap_r} > (CAP_W + 1)'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end

    ptr_ext = CNT_W'(ptr_r);
    if (ptr_ext >= fill_r) begin
      oldest = ptr_ext - fill_r;
    end else begin
      oldest = ptr_ext + CNT_W'(ENTRIES) - fill_r;
    end

    insert = fire && (req.cmd == CMD_UPDATE) && !match.hit;
    evict  = insert && (fill_r >= cap_eff) && (fill_r != '0);

    ptr_nxt  = ptr_r;
    fill_nxt = fill_r;
    if (insert) begin
      ptr_nxt = (ptr_r == IDX_W'(ENTRIES - 1)) ? '0 : ptr_r + 1'b1;
      if (!evict && fill_r < CNT_W'(ENTRIES)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end

    wr           = '0;
    wr.evict     = evict;
    wr.evict_idx = oldest[IDX_W-1:0];
    wr.key       = {req.family_id, req.column_id, req.row_id};
    wr.value     = req.value;
    wr.wr        = fire && (req.cmd == CMD_UPDATE);
    wr.wr_key    = insert;
    wr.wr_idx    = insert ? ptr_r : match.idx;
    wr.mark      = fire && (req.cmd == CMD_DELETE) && match.hit;

    result            = '0;
    result.ok         = (req.cmd == CMD_UPDATE) || match.hit;
    result.deleted    = (req.cmd != CMD_UPDATE) && match.hit &&
                        ((req.cmd == CMD_DELETE) || match.tomb);
    result.read_value = ((req.cmd == CMD_READ) && match.hit && !match.tomb) ?
                        match.value : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_W'(ENTRIES);
      ptr_r  <= '0;
      fill_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      ptr_r  <= ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

@@ rtl/core/fifo_replacement_key_value_cache.sv @@
// Top level of the FIFO-replacement key-value cache: input register, lookup/update pass,
// result register and handshakes. Uses kvc_pkg, kvc_entry_store and kvc_policy.
//
// Takes one request transaction per clock while the output is not stalled and returns one
// result transaction per request, in order. The request is captured in an input register, the
// key is compared against all 16 entries, and when the request fires the chosen entry is
// written and the result is captured in the output register. The combinational 16-way key
// compare plus one entry write sets the one-request-per-cycle rate. The capacity register
// (cfg_data) must be written only while no request is in flight; cfg_ready is always high.
module fifo_replacement_key_value_cache
  import kvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  logic      in_vld_r, in_vld_nxt;
  in_item_t  in_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_r;
  logic      fire;
  logic      in_accept;
  match_t    match;
  store_wr_t wr;
  out_item_t result;

  assign fire      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !fire;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_item;
    end
    if (fire) begin
      out_r <= result;
    end
  end

  kvc_entry_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .lookup_key ({in_r.family_id, in_r.column_id, in_r.row_id}),
    .wr         (wr),
    .match      (match)
  );

  kvc_policy u_policy (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .fire     (fire),
    .req      (in_r),
    .match    (match),
    .wr       (wr),
    .result   (result)
  );

  a_update_ok: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_r.cmd == CMD_UPDATE |=> out_valid && out_item.ok)
    else $error("update transaction did not return ok");

  a_no_stall_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> !in_stall)
    else $error("input stalled while result register empty");

  a_read_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.read_value != '0 |-> out_item.ok && !out_item.deleted)
    else $error("nonzero read value without live hit");

endmodule
